>>> rtl/tt_pkg.sv
// Package for the transposition table: field widths, request and bound codes,
// slot layout, controller states and the command/status structs.
// No dependencies.
`default_nettype none

package tt_pkg;

   // Field widths
   localparam int KEY_W   = 64;
   localparam int MOVE_W  = 32;
   localparam int SCORE_W = 16;
   localparam int DEPTH_W = 7;
   localparam int PLY_W   = 7;
   localparam int THR_W   = 15;
   localparam int REQ_W   = 2;
   localparam int BOUND_W = 2;

   // Defaults for the top-level parameters
   localparam int ENTRIES_DEF = 1024;
   localparam int MAX_PLY_DEF = 128;

   // Score saturation limit and mate threshold after reset
   localparam int SCORE_LIM = 32767;
   localparam logic [THR_W-1:0] THR_RESET = 15'd9900;

   // Key bits folded into the remainder per cycle by the index unit
   localparam int MOD_STEP = 4;
   localparam int MOD_CYC  = KEY_W / MOD_STEP;

   typedef enum logic [REQ_W-1:0] {
      REQ_STORE  = 2'd0,
      REQ_PROBE  = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_UNUSED = 2'd3
   } req_kind_type;

   typedef enum logic [BOUND_W-1:0] {
      BOUND_UPPER  = 2'd0,
      BOUND_LOWER  = 2'd1,
      BOUND_EXACT  = 2'd2,
      BOUND_UNUSED = 2'd3
   } bound_type;

   typedef struct packed {
      logic [KEY_W-1:0]          key;
      logic [MOVE_W-1:0]         move;
      logic signed [SCORE_W-1:0] score;
      bound_type                 bound;
      logic [DEPTH_W-1:0]        depth;
   } slot_type;

   typedef enum logic [2:0] {
      ST_CLEAR   = 3'd0,
      ST_IDLE    = 3'd1,
      ST_INDEX   = 3'd2,
      ST_READ    = 3'd3,
      ST_ADJUST  = 3'd4,
      ST_WRITE   = 3'd5,
      ST_RESPOND = 3'd6
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic latch;
      logic idx_go;
      logic rd_en;
      logic adj_en;
      logic st_wr;
      logic sweep_init;
      logic sweep_wr;
      logic rsp_load;
      logic rsp_probe;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic idx_done;
      logic sweep_last;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/tt_mod.sv
// Slot index unit: position key modulo ENTRIES.
// A power-of-two table registers the low key bits; any other size runs
// a restoring remainder, MOD_STEP key bits per cycle. Depends on tt_pkg.
`default_nettype none

module tt_mod #(
   parameter int ENTRIES = tt_pkg::ENTRIES_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         go,
   input  wire logic [tt_pkg::KEY_W-1:0]     key,
   output logic                              done,
   output logic [$clog2(ENTRIES)-1:0]        idx
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam bit IS_POW2 = ((ENTRIES & (ENTRIES - 1)) == 0);

   generate
      if (IS_POW2) begin : g_mask
         logic             done_ff;
         logic [IDX_W-1:0] idx_ff;

         // Take the low key bits
         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= go;
            end
            if (go) begin
               idx_ff <= key[IDX_W-1:0];
            end
         end

         assign done = done_ff;
         assign idx  = idx_ff;
      end else begin : g_rem
         localparam int CNT_W = $clog2(tt_pkg::MOD_CYC);
         localparam logic [IDX_W:0] MOD_E = (IDX_W + 1)'(ENTRIES);
         localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(tt_pkg::MOD_CYC - 1);

         logic                     run_ff, run_in;
         logic                     done_ff, done_in;
         logic [CNT_W-1:0]         cnt_ff, cnt_in;
         logic [tt_pkg::KEY_W-1:0] key_ff, key_in;
         logic [IDX_W-1:0]         rem_ff, rem_in;
         logic [IDX_W-1:0]         rem_step;

         // Fold the next group of key bits into the remainder
         always_comb begin
            logic [IDX_W:0] t;
            rem_step = rem_ff;
            for (int i = 0; i < tt_pkg::MOD_STEP; i++) begin
               t = {rem_step, key_ff[tt_pkg::KEY_W-1-i]};
               if (t >= MOD_E) begin
                  t = t - MOD_E;
               end
               rem_step = t[IDX_W-1:0];
            end
         end

         // Advance the sweep over the key, most significant bits first
         always_comb begin
            run_in  = run_ff;
            done_in = 1'b0;
            cnt_in  = cnt_ff;
            key_in  = key_ff;
            rem_in  = rem_ff;
            if (go) begin
               run_in = 1'b1;
               cnt_in = '0;
               key_in = key;
               rem_in = '0;
            end else if (run_ff) begin
               key_in = key_ff << tt_pkg::MOD_STEP;
               rem_in = rem_step;
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == CNT_LAST) begin
                  run_in  = 1'b0;
                  done_in = 1'b1;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b0;
               cnt_ff  <= '0;
            end else begin
               run_ff  <= run_in;
               done_ff <= done_in;
               cnt_ff  <= cnt_in;
            end
            key_ff <= key_in;
            rem_ff <= rem_in;
         end

         assign done = done_ff;
         assign idx  = rem_ff;
      end
   endgenerate

endmodule

`default_nettype wire

>>> rtl/tt_dpath.sv
// Datapath of the transposition table: request registers, slot memory,
// mate-score adjustment, window clamp, result registers and the clear sweep.
// Depends on tt_pkg and tt_mod.
`default_nettype none

module tt_dpath #(
   parameter int ENTRIES = tt_pkg::ENTRIES_DEF,
   parameter int MAX_PLY = tt_pkg::MAX_PLY_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire tt_pkg::cmd_type                   cmd,
   output tt_pkg::status_type                     status,
   input  wire logic                              csr_wr,
   input  wire logic [tt_pkg::THR_W-1:0]          csr_data,
   input  wire logic [tt_pkg::KEY_W-1:0]          req_position_key,
   input  wire logic [tt_pkg::MOVE_W-1:0]         req_move_code,
   input  wire logic signed [tt_pkg::SCORE_W-1:0] req_score_in,
   input  wire logic [tt_pkg::BOUND_W-1:0]        req_bound_kind,
   input  wire logic [tt_pkg::DEPTH_W-1:0]        req_search_depth,
   input  wire logic [tt_pkg::PLY_W-1:0]          req_ply_from_root,
   input  wire logic signed [tt_pkg::SCORE_W-1:0] req_window_low,
   input  wire logic signed [tt_pkg::SCORE_W-1:0] req_window_high,
   output logic                                   rsp_strobe,
   output logic                                   rsp_key_matched,
   output logic                                   rsp_cutoff_hit,
   output logic [tt_pkg::MOVE_W-1:0]              rsp_move_out,
   output logic signed [tt_pkg::SCORE_W-1:0]      rsp_score_out,
   output logic                                   rsp_score_valid
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int PLY_MAX_W = (1 << tt_pkg::PLY_W) - 1;
   localparam int PLY_CAP = (MAX_PLY - 1 > PLY_MAX_W) ? PLY_MAX_W : MAX_PLY - 1;
   localparam logic [IDX_W-1:0] SWEEP_LAST = IDX_W'(ENTRIES - 1);
   localparam int WIDE_W = tt_pkg::SCORE_W + 2;

   typedef logic signed [WIDE_W-1:0] wide_type;

   // Clamp a widened score to the symmetric score range
   function automatic logic signed [tt_pkg::SCORE_W-1:0] sat_score(input wide_type s);
      wide_type lim;
      lim = WIDE_W'(tt_pkg::SCORE_LIM);
      if (s > lim) begin
         return tt_pkg::SCORE_W'(tt_pkg::SCORE_LIM);
      end else if (s < -lim) begin
         return tt_pkg::SCORE_W'(-tt_pkg::SCORE_LIM);
      end
      return s[tt_pkg::SCORE_W-1:0];
   endfunction

   // Request registers
   logic [tt_pkg::KEY_W-1:0]          key_ff;
   logic [tt_pkg::MOVE_W-1:0]         move_ff;
   logic signed [tt_pkg::SCORE_W-1:0] score_ff;
   tt_pkg::bound_type                 bound_ff;
   logic [tt_pkg::DEPTH_W-1:0]        depth_ff;
   logic [tt_pkg::PLY_W-1:0]          ply_ff;
   logic signed [tt_pkg::SCORE_W-1:0] lo_ff;
   logic signed [tt_pkg::SCORE_W-1:0] hi_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         key_ff   <= req_position_key;
         move_ff  <= req_move_code;
         score_ff <= req_score_in;
         bound_ff <= tt_pkg::bound_type'(req_bound_kind);
         depth_ff <= req_search_depth;
         ply_ff   <= (req_ply_from_root > tt_pkg::PLY_W'(PLY_CAP)) ?
                     tt_pkg::PLY_W'(PLY_CAP) : req_ply_from_root;
         lo_ff    <= req_window_low;
         hi_ff    <= req_window_high;
      end
   end

   // Mate threshold register
   logic [tt_pkg::THR_W-1:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= tt_pkg::THR_RESET;
      end else if (csr_wr) begin
         thr_ff <= csr_data;
      end
   end

   // Slot index
   logic [IDX_W-1:0] idx;
   logic             idx_done;

   tt_mod #(
      .ENTRIES (ENTRIES)
   ) u_mod (
      .clock (clock),
      .reset (reset),
      .go    (cmd.idx_go),
      .key   (req_position_key),
      .done  (idx_done),
      .idx   (idx)
   );

   // Clear sweep address
   logic [IDX_W-1:0] sweep_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.sweep_init) begin
         sweep_ff <= '0;
      end else if (cmd.sweep_wr) begin
         sweep_ff <= sweep_ff + 1'b1;
      end
   end

   assign status = '{idx_done: idx_done, sweep_last: (sweep_ff == SWEEP_LAST)};

   // Shared widened operands for the mate adjustment
   wide_type thr_w;
   wide_type ply_w;

   assign thr_w = wide_type'({3'b000, thr_ff});
   assign ply_w = wide_type'({{(WIDE_W - tt_pkg::PLY_W){1'b0}}, ply_ff});

   // Push a mate score away from zero by the ply before storing
   wide_type         st_wide;
   tt_pkg::slot_type slot_wr;

   always_comb begin
      wide_type s;
      s = wide_type'(score_ff);
      st_wide = s;
      if (s > thr_w) begin
         st_wide = s + ply_w;
      end else if (s < -thr_w) begin
         st_wide = s - ply_w;
      end
      slot_wr.key   = key_ff;
      slot_wr.move  = move_ff;
      slot_wr.score = sat_score(st_wide);
      slot_wr.bound = bound_ff;
      slot_wr.depth = depth_ff;
   end

   // Slot memory: one write port, one registered read port
   tt_pkg::slot_type mem [ENTRIES];
   tt_pkg::slot_type rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.sweep_wr) begin
         mem[sweep_ff] <= '0;
      end else if (cmd.st_wr) begin
         mem[idx] <= slot_wr;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[idx];
      end
   end

   // Match, depth check and pull a mate score back toward zero
   logic                              hit_ff;
   logic                              deep_ff;
   logic signed [tt_pkg::SCORE_W-1:0] sc_ff;
   logic [tt_pkg::MOVE_W-1:0]         smove_ff;
   tt_pkg::bound_type                 sbound_ff;
   wide_type                          pr_wide;

   always_comb begin
      wide_type s;
      s = wide_type'(rd_ff.score);
      pr_wide = s;
      if (s > thr_w) begin
         pr_wide = s - ply_w;
      end else if (s < -thr_w) begin
         pr_wide = s + ply_w;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.adj_en) begin
         hit_ff    <= (rd_ff.key == key_ff);
         deep_ff   <= (rd_ff.depth >= depth_ff);
         sc_ff     <= sat_score(pr_wide);
         smove_ff  <= rd_ff.move;
         sbound_ff <= rd_ff.bound;
      end
   end

   // Clamp against the window according to the bound kind
   logic                              cut;
   logic signed [tt_pkg::SCORE_W-1:0] sc_fin;

   always_comb begin
      cut    = 1'b0;
      sc_fin = sc_ff;
      unique case (sbound_ff)
         tt_pkg::BOUND_UPPER: begin
            if (sc_ff <= lo_ff) begin
               cut    = 1'b1;
               sc_fin = lo_ff;
            end
         end
         tt_pkg::BOUND_LOWER: begin
            if (sc_ff >= hi_ff) begin
               cut    = 1'b1;
               sc_fin = hi_ff;
            end
         end
         tt_pkg::BOUND_EXACT: begin
            cut = 1'b1;
         end
         default: begin
            cut = 1'b0;
         end
      endcase
   end

   // Result registers
   logic                              strobe_ff;
   logic                              matched_ff, matched_in;
   logic                              cut_ff, cut_in;
   logic [tt_pkg::MOVE_W-1:0]         mout_ff, mout_in;
   logic signed [tt_pkg::SCORE_W-1:0] sout_ff, sout_in;
   logic                              sval_ff, sval_in;

   always_comb begin
      matched_in = 1'b0;
      cut_in     = 1'b0;
      mout_in    = '0;
      sout_in    = '0;
      sval_in    = 1'b0;
      if (cmd.rsp_probe && hit_ff) begin
         matched_in = 1'b1;
         mout_in    = smove_ff;
         if (deep_ff) begin
            sval_in = 1'b1;
            cut_in  = cut;
            sout_in = sc_fin;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.rsp_load;
      end
      if (cmd.rsp_load) begin
         matched_ff <= matched_in;
         cut_ff     <= cut_in;
         mout_ff    <= mout_in;
         sout_ff    <= sout_in;
         sval_ff    <= sval_in;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_key_matched = matched_ff;
   assign rsp_cutoff_hit  = cut_ff;
   assign rsp_move_out    = mout_ff;
   assign rsp_score_out   = sout_ff;
   assign rsp_score_valid = sval_ff;

endmodule

`default_nettype wire

>>> rtl/tt_ctrl.sv
// Controller of the transposition table: accepts requests, sequences the
// index, read, adjust, write and clear steps. Depends on tt_pkg.
`default_nettype none

module tt_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [tt_pkg::REQ_W-1:0]  req_type,
   output logic                           busy,
   output tt_pkg::cmd_type                cmd,
   input  wire tt_pkg::status_type        status
);

   tt_pkg::ctrl_state_type state_ff, state_in;
   tt_pkg::req_kind_type   op_ff, op_in;

   // State and operation registers; reset starts the clear sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tt_pkg::ST_CLEAR;
         op_ff    <= tt_pkg::REQ_UNUSED;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   assign busy = (state_ff != tt_pkg::ST_IDLE);

   // Next state and commands
   always_comb begin
      tt_pkg::req_kind_type kind;
      kind     = tt_pkg::req_kind_type'(req_type);
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      unique case (state_ff)
         tt_pkg::ST_CLEAR: begin
            cmd.sweep_wr = 1'b1;
            if (status.sweep_last) begin
               state_in = (op_ff == tt_pkg::REQ_CLEAR) ? tt_pkg::ST_RESPOND :
                          tt_pkg::ST_IDLE;
            end
         end
         tt_pkg::ST_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               op_in     = kind;
               unique case (kind)
                  tt_pkg::REQ_STORE, tt_pkg::REQ_PROBE: begin
                     cmd.idx_go = 1'b1;
                     state_in   = tt_pkg::ST_INDEX;
                  end
                  tt_pkg::REQ_CLEAR: begin
                     cmd.sweep_init = 1'b1;
                     state_in       = tt_pkg::ST_CLEAR;
                  end
                  default: begin
                     state_in = tt_pkg::ST_RESPOND;
                  end
               endcase
            end
         end
         tt_pkg::ST_INDEX: begin
            if (status.idx_done) begin
               state_in = (op_ff == tt_pkg::REQ_STORE) ? tt_pkg::ST_WRITE :
                          tt_pkg::ST_READ;
            end
         end
         tt_pkg::ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = tt_pkg::ST_ADJUST;
         end
         tt_pkg::ST_ADJUST: begin
            cmd.adj_en = 1'b1;
            state_in   = tt_pkg::ST_RESPOND;
         end
         tt_pkg::ST_WRITE: begin
            cmd.st_wr = 1'b1;
            state_in  = tt_pkg::ST_RESPOND;
         end
         tt_pkg::ST_RESPOND: begin
            cmd.rsp_load  = 1'b1;
            cmd.rsp_probe = (op_ff == tt_pkg::REQ_PROBE);
            state_in      = tt_pkg::ST_IDLE;
         end
         default: begin
            state_in = tt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/transposition_table.sv
// Transposition table: direct-mapped, always-replace search cache.
// Request channel: start with req_* fields, taken when start is high and busy
// is low. req_type selects store, probe or clear; an unused code gives an
// all-zero result and changes nothing.
// Result channel: one result per request on rsp_* for a single cycle, marked
// by rsp_strobe. The receiver cannot stall; every result is taken as shown.
// Configuration: csr_valid with csr_mate_threshold; csr_ready is always high.
// Steps from accept to strobe, set by the controller's step sequence:
//   probe: index, read, adjust, respond; store: index, write, respond; unused code: respond;
//   other sizes run the bit-serial modulo in the index step.
//   clear: sweep, then respond, one slot written per cycle through the single
//   memory write port. busy is low again in the strobe cycle, so the next
//   request may be accepted then.
// Reset: the mate threshold returns to 9900 and a clearing pass zeroes all
// ENTRIES slots, one per cycle; busy stays high after reset is released
// until that pass has written the last slot.
// Depends on tt_pkg, tt_ctrl, tt_dpath, tt_mod.
`default_nettype none

module transposition_table #(
   parameter int ENTRIES = tt_pkg::ENTRIES_DEF,
   parameter int MAX_PLY = tt_pkg::MAX_PLY_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [tt_pkg::REQ_W-1:0]          req_type,
   input  wire logic [tt_pkg::KEY_W-1:0]          req_position_key,
   input  wire logic [tt_pkg::MOVE_W-1:0]         req_move_code,
   input  wire logic signed [tt_pkg::SCORE_W-1:0] req_score_in,
   input  wire logic [tt_pkg::BOUND_W-1:0]        req_bound_kind,
   input  wire logic [tt_pkg::DEPTH_W-1:0]        req_search_depth,
   input  wire logic [tt_pkg::PLY_W-1:0]          req_ply_from_root,
   input  wire logic signed [tt_pkg::SCORE_W-1:0] req_window_low,
   input  wire logic signed [tt_pkg::SCORE_W-1:0] req_window_high,
   output logic                                   rsp_strobe,
   output logic                                   rsp_key_matched,
   output logic                                   rsp_cutoff_hit,
   output logic [tt_pkg::MOVE_W-1:0]              rsp_move_out,
   output logic signed [tt_pkg::SCORE_W-1:0]      rsp_score_out,
   output logic                                   rsp_score_valid,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [tt_pkg::THR_W-1:0]          csr_mate_threshold
);

   tt_pkg::cmd_type    cmd;
   tt_pkg::status_type status;

   // Threshold writes are taken in any cycle
   assign csr_ready = 1'b1;

   tt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .busy     (busy),
      .cmd      (cmd),
      .status   (status)
   );

   tt_dpath #(
      .ENTRIES (ENTRIES),
      .MAX_PLY (MAX_PLY)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_wr            (csr_valid),
      .csr_data          (csr_mate_threshold),
      .req_position_key  (req_position_key),
      .req_move_code     (req_move_code),
      .req_score_in      (req_score_in),
      .req_bound_kind    (req_bound_kind),
      .req_search_depth  (req_search_depth),
      .req_ply_from_root (req_ply_from_root),
      .req_window_low    (req_window_low),
      .req_window_high   (req_window_high),
      .rsp_strobe        (rsp_strobe),
      .rsp_key_matched   (rsp_key_matched),
      .rsp_cutoff_hit    (rsp_cutoff_hit),
      .rsp_move_out      (rsp_move_out),
      .rsp_score_out     (rsp_score_out),
      .rsp_score_valid   (rsp_score_valid)
   );

endmodule

`default_nettype wire

>>> tb/transposition_table_test.sv
`timescale 1ns / 100ps
// Self-checking bench for transposition_table: store, probe, clear and unused
// requests are predicted by an in-bench copy of the slot table and checked.
// Depends on tt_pkg and the transposition_table RTL.

module transposition_table_test;
   import tt_pkg::*;

   localparam int ENTRIES      = 1024;
   localparam int MAX_PLY      = 128;
   localparam int IDX_W        = $clog2(ENTRIES);
   localparam int IDLE_LIMIT   = 4 * ENTRIES + 1000;
   localparam int DRAIN_CYCLES = 20;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 183;
   localparam int POOL_DEPTH   = 48;

   typedef enum {OP_REQUEST, OP_SET_THRESHOLD, OP_WAIT_IDLE} op_kind_type;

   // One queued step for the driver: a request item, a threshold write or a pause
   typedef struct {
      op_kind_type               kind;
      int unsigned               gap;
      req_kind_type              rtype;
      logic [KEY_W-1:0]          key;
      logic [MOVE_W-1:0]         move;
      logic signed [SCORE_W-1:0] score;
      bound_type                 bound;
      logic [DEPTH_W-1:0]        depth;
      logic [PLY_W-1:0]          ply;
      logic signed [SCORE_W-1:0] lo;
      logic signed [SCORE_W-1:0] hi;
      logic [THR_W-1:0]          threshold;
   } table_op_type;

   typedef struct {
      logic                      key_matched;
      logic                      cutoff_hit;
      logic [MOVE_W-1:0]         move;
      logic signed [SCORE_W-1:0] score;
      logic                      score_valid;
   } lookup_result_type;

   typedef struct {
      logic [KEY_W-1:0] key;
      int               score;
   } stored_key_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [REQ_W-1:0]          req_type = '0;
   logic [KEY_W-1:0]          req_position_key = '0;
   logic [MOVE_W-1:0]         req_move_code = '0;
   logic signed [SCORE_W-1:0] req_score_in = '0;
   logic [BOUND_W-1:0]        req_bound_kind = '0;
   logic [DEPTH_W-1:0]        req_search_depth = '0;
   logic [PLY_W-1:0]          req_ply_from_root = '0;
   logic signed [SCORE_W-1:0] req_window_low = '0;
   logic signed [SCORE_W-1:0] req_window_high = '0;
   logic                      rsp_strobe;
   logic                      rsp_key_matched;
   logic                      rsp_cutoff_hit;
   logic [MOVE_W-1:0]         rsp_move_out;
   logic signed [SCORE_W-1:0] rsp_score_out;
   logic                      rsp_score_valid;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [THR_W-1:0]          csr_mate_threshold = '0;

   slot_type          table_model [ENTRIES];
   int                mate_limit_model;
   table_op_type      op_queue [$];
   lookup_result_type expected_lookups [$];
   stored_key_type    stored_keys [$];
   table_op_type      op_on_bus;
   int unsigned       idle_count;
   int unsigned       items_taken = 0;
   int unsigned       results_seen = 0;
   int unsigned       quiet_cycles = 0;
   int                error_count = 0;
   logic              start_next;
   logic              csr_next;

   transposition_table #(
      .ENTRIES(ENTRIES),
      .MAX_PLY(MAX_PLY)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_position_key  (req_position_key),
      .req_move_code     (req_move_code),
      .req_score_in      (req_score_in),
      .req_bound_kind    (req_bound_kind),
      .req_search_depth  (req_search_depth),
      .req_ply_from_root (req_ply_from_root),
      .req_window_low    (req_window_low),
      .req_window_high   (req_window_high),
      .rsp_strobe        (rsp_strobe),
      .rsp_key_matched   (rsp_key_matched),
      .rsp_cutoff_hit    (rsp_cutoff_hit),
      .rsp_move_out      (rsp_move_out),
      .rsp_score_out     (rsp_score_out),
      .rsp_score_valid   (rsp_score_valid),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_mate_threshold(csr_mate_threshold)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int clamp_score(int s);
      if (s > SCORE_LIM) return SCORE_LIM;
      if (s < -SCORE_LIM) return -SCORE_LIM;
      return s;
   endfunction

   // Apply one request to the slot table copy and return the result it gives
   function automatic lookup_result_type predict_lookup(table_op_type op);
      lookup_result_type r;
      slot_type          s;
      int                slot;
      int                ply;
      int                sc;
      int                lo;
      int                hi;
      r    = '{default: '0};
      slot = int'(op.key % ENTRIES);
      ply  = (op.ply > MAX_PLY - 1) ? MAX_PLY - 1 : int'(op.ply);
      lo   = int'(op.lo);
      hi   = int'(op.hi);
      case (op.rtype)
         REQ_STORE: begin
            // push mate scores away from zero so the entry is ply-independent
            sc = int'(op.score);
            if (sc > mate_limit_model) sc += ply;
            else if (sc < -mate_limit_model) sc -= ply;
            sc = clamp_score(sc);
            table_model[slot] = '{key: op.key, move: op.move, score: sc[SCORE_W-1:0],
                                  bound: op.bound, depth: op.depth};
         end
         REQ_PROBE: begin
            s = table_model[slot];
            if (s.key == op.key) begin
               r.key_matched = 1'b1;
               r.move        = s.move;
               if (s.depth >= op.depth) begin
                  sc = int'(s.score);
                  if (sc > mate_limit_model) sc -= ply;
                  else if (sc < -mate_limit_model) sc += ply;
                  sc = clamp_score(sc);
                  case (s.bound)
                     BOUND_UPPER: if (sc <= lo) begin
                        sc           = lo;
                        r.cutoff_hit = 1'b1;
                     end
                     BOUND_LOWER: if (sc >= hi) begin
                        sc           = hi;
                        r.cutoff_hit = 1'b1;
                     end
                     BOUND_EXACT: r.cutoff_hit = 1'b1;
                     default: ;
                  endcase
                  r.score       = sc[SCORE_W-1:0];
                  r.score_valid = 1'b1;
               end
            end
         end
         REQ_CLEAR: foreach (table_model[i]) table_model[i] = '0;
         default: ;
      endcase
      return r;
   endfunction

   function automatic int unsigned pick_gap(bit steady);
      int unsigned roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 4);
      if (roll < 97) return $urandom_range(5, 12);
      return $urandom_range(20, 60);
   endfunction

   // Mostly scores near the mate limit, the saturation limit or zero; some fully random
   function automatic int pick_score(int thr);
      int mag;
      case ($urandom_range(0, 9))
         0, 1: mag = thr - 64 + int'($urandom_range(0, 192));
         2: mag = SCORE_LIM - int'($urandom_range(0, 140));
         3: return int'($signed(16'($urandom)));
         default: return int'($urandom_range(0, 4000)) - 2000;
      endcase
      if (mag > SCORE_LIM) mag = SCORE_LIM - int'($urandom_range(0, 63));
      if (mag < 0) mag = 0;
      return $urandom_range(0, 1) ? mag : -mag;
   endfunction

   function automatic table_op_type request_op(req_kind_type rtype, logic [KEY_W-1:0] key,
                                               logic [MOVE_W-1:0] move, int score,
                                               bound_type bound, int depth, int ply,
                                               int lo, int hi);
      table_op_type op;
      op.kind      = OP_REQUEST;
      op.gap       = pick_gap(1'b0);
      op.rtype     = rtype;
      op.key       = key;
      op.move      = move;
      op.score     = score[SCORE_W-1:0];
      op.bound     = bound;
      op.depth     = depth[DEPTH_W-1:0];
      op.ply       = ply[PLY_W-1:0];
      op.lo        = lo[SCORE_W-1:0];
      op.hi        = hi[SCORE_W-1:0];
      op.threshold = '0;
      return op;
   endfunction

   // Stores and probes, most probes of recently stored keys, plus rare clears and unused codes
   function automatic table_op_type random_op(int thr, bit steady);
      table_op_type   op;
      stored_key_type entry;
      int unsigned    roll;
      int unsigned    pick;
      int             centre;
      op.kind      = OP_REQUEST;
      op.gap       = pick_gap(steady);
      op.threshold = '0;
      op.key       = {$urandom, $urandom};
      op.move      = $urandom;
      op.score     = 16'(pick_score(thr));
      op.bound     = ($urandom_range(0, 19) == 0) ? BOUND_UNUSED
                                                  : bound_type'($urandom_range(0, 2));
      op.depth     = DEPTH_W'($urandom);
      op.ply       = PLY_W'($urandom);
      op.lo        = SCORE_W'($urandom);
      op.hi        = SCORE_W'($urandom);
      roll         = $urandom_range(0, 999);
      if (roll < 6) begin
         op.rtype = REQ_CLEAR;
         stored_keys.delete();
      end else if (roll < 30) begin
         op.rtype = REQ_UNUSED;
      end else if (roll < 450) begin
         op.rtype = REQ_STORE;
         if (stored_keys.size() != 0 && $urandom_range(0, 9) < 4) begin
            entry = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            // overwrite the same key, or evict it with another key on its slot
            if ($urandom_range(0, 3) == 0) op.key[IDX_W-1:0] = entry.key[IDX_W-1:0];
            else op.key = entry.key;
         end else if ($urandom_range(0, 49) == 0) begin
            op.key = '0;
         end
         stored_keys.push_back('{op.key, int'(op.score)});
         if (stored_keys.size() > POOL_DEPTH) stored_keys.delete(0);
      end else begin
         op.rtype = REQ_PROBE;
         if ($urandom_range(0, 1)) op.depth = DEPTH_W'($urandom_range(0, 40));
         pick = $urandom_range(0, 19);
         if (stored_keys.size() != 0 && pick < 15) begin
            entry = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            if (pick == 14) begin
               op.key[IDX_W-1:0] = entry.key[IDX_W-1:0];
            end else begin
               op.key = entry.key;
               // centre most windows on the stored score so both bound outcomes occur
               if ($urandom_range(0, 9) != 0) begin
                  centre = entry.score + int'($urandom_range(0, 600)) - 300;
                  op.lo  = 16'(centre - int'($urandom_range(0, 300)));
                  op.hi  = 16'(centre + int'($urandom_range(0, 300)));
               end
            end
         end else if (pick == 15) begin
            op.key = '0;
         end
      end
      return op;
   endfunction

   // Drive queued steps; fold the handshakes of the edge just passed into the model
   always @(posedge clock) begin : drive_requests
      if (reset) begin
         foreach (table_model[i]) table_model[i] = '0;
         mate_limit_model = int'(THR_RESET);
         idle_count       = 0;
         start     <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_lookups.push_back(predict_lookup(op_on_bus));
            items_taken <= items_taken + 1;
         end
         if (csr_valid && csr_ready) mate_limit_model = int'(csr_mate_threshold);
         start_next = 1'b0;
         csr_next   = 1'b0;
         if (start && busy) begin
            start_next = 1'b1;
         end else if (csr_valid && !csr_ready) begin
            csr_next = 1'b1;
         end else if (op_queue.size() != 0) begin
            case (op_queue[0].kind)
               OP_REQUEST: begin
                  if (idle_count < op_queue[0].gap) begin
                     idle_count++;
                  end else begin
                     op_on_bus  = op_queue.pop_front();
                     idle_count = 0;
                     start_next = 1'b1;
                     req_type          <= op_on_bus.rtype;
                     req_position_key  <= op_on_bus.key;
                     req_move_code     <= op_on_bus.move;
                     req_score_in      <= op_on_bus.score;
                     req_bound_kind    <= op_on_bus.bound;
                     req_search_depth  <= op_on_bus.depth;
                     req_ply_from_root <= op_on_bus.ply;
                     req_window_low    <= op_on_bus.lo;
                     req_window_high   <= op_on_bus.hi;
                  end
               end
               OP_SET_THRESHOLD: begin
                  // write only once the table is idle and every result is back
                  if (!start && !busy && items_taken == results_seen) begin
                     csr_mate_threshold <= op_queue[0].threshold;
                     csr_next = 1'b1;
                     op_queue.delete(0);
                  end
               end
               OP_WAIT_IDLE: begin
                  if (!start && items_taken == results_seen) op_queue.delete(0);
               end
               default: ;
            endcase
         end
         start     <= start_next;
         csr_valid <= csr_next;
      end
   end

   task automatic check_field(string name, logic signed [32:0] want, logic signed [32:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Compare each strobed result with the oldest prediction
   always @(posedge clock) begin : watch_results
      lookup_result_type want;
      if (!reset && rsp_strobe) begin
         results_seen <= results_seen + 1;
         if (expected_lookups.size() == 0) begin
            $error("result strobed with no request outstanding");
            error_count++;
         end else begin
            want = expected_lookups.pop_front();
            check_field("key_matched", 33'(want.key_matched), 33'(rsp_key_matched));
            check_field("cutoff_hit", 33'(want.cutoff_hit), 33'(rsp_cutoff_hit));
            check_field("move_out", 33'(want.move), 33'(rsp_move_out));
            check_field("score_out", 33'(want.score), 33'(rsp_score_out));
            check_field("score_valid", 33'(want.score_valid), 33'(rsp_score_valid));
         end
      end
   end

   // Count cycles with no handshake of any kind
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe === 1'b1 || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      int           phase_limits [PHASES];
      table_op_type op;
      int           thr;
      // directed items under the reset threshold
      op_queue.push_back(request_op(REQ_PROBE, '0, '0, 0, BOUND_UPPER, 0, 0, 0, 0));
      op_queue.push_back(request_op(REQ_STORE, '1, '1, 32767, BOUND_EXACT, 127, 127,
                                    0, 0));
      op_queue.push_back(request_op(REQ_PROBE, '1, '0, 0, BOUND_UPPER, 127, 127,
                                    -32767, 32767));
      op_queue.push_back(request_op(REQ_STORE, 64'h5, 32'h1234_5678, -32768, BOUND_LOWER,
                                    0, 5, 0, 0));
      op_queue.push_back(request_op(REQ_PROBE, 64'h5, '0, 0, BOUND_UPPER, 0, 0,
                                    0, -32767));
      op_queue.push_back(request_op(REQ_STORE, 64'hA000_0000_0000_0011, 32'h0000_0AAA, 100,
                                    BOUND_UPPER, 10, 3, 0, 0));
      op_queue.push_back(request_op(REQ_PROBE, 64'hA000_0000_0000_0011, '0, 0, BOUND_UPPER,
                                    10, 3, 200, 400));
      op_queue.push_back(request_op(REQ_PROBE, 64'hA000_0000_0000_0011, '0, 0, BOUND_UPPER,
                                    9, 3, 50, 400));
      op_queue.push_back(request_op(REQ_PROBE, 64'hA000_0000_0000_0011, '0, 0, BOUND_UPPER,
                                    11, 3, 50, 400));
      op_queue.push_back(request_op(REQ_PROBE, 64'hB000_0000_0000_0011, '0, 0, BOUND_UPPER,
                                    0, 0, 0, 0));
      op_queue.push_back(request_op(REQ_STORE, 64'h22, 32'h0000_0BBB, 100, BOUND_LOWER,
                                    4, 0, 0, 0));
      op_queue.push_back(request_op(REQ_PROBE, 64'h22, '0, 0, BOUND_UPPER, 4, 0, -50, 50));
      op_queue.push_back(request_op(REQ_PROBE, 64'h22, '0, 0, BOUND_UPPER, 4, 0, -50, 200));
      op_queue.push_back(request_op(REQ_PROBE, 64'h22, '0, 0, BOUND_UPPER, 0, 0, 300, -300));
      op_queue.push_back(request_op(REQ_STORE, 64'h33, 32'h0000_0CCC, 500, BOUND_UNUSED,
                                    2, 0, 0, 0));
      op_queue.push_back(request_op(REQ_PROBE, 64'h33, '0, 0, BOUND_UPPER, 2, 0, 600, 400));
      op_queue.push_back(request_op(REQ_STORE, 64'h44, 32'h0000_0DDD, -10000, BOUND_EXACT,
                                    6, 10, 0, 0));
      op_queue.push_back(request_op(REQ_PROBE, 64'h44, '0, 0, BOUND_UPPER, 6, 3, 0, 0));
      op_queue.push_back(request_op(REQ_STORE, 64'h55, 32'h0000_0EEE, 9901, BOUND_UPPER,
                                    8, 127, 0, 0));
      op_queue.push_back(request_op(REQ_PROBE, 64'h55, '0, 0, BOUND_UPPER, 8, 0,
                                    32767, 32767));
      op_queue.push_back(request_op(REQ_UNUSED, '1, '1, -1, BOUND_UNUSED, 127, 127, -1, -1));
      op_queue.push_back(request_op(REQ_CLEAR, '0, '0, 0, BOUND_UPPER, 0, 0, 0, 0));
      op_queue.push_back(request_op(REQ_PROBE, '1, '0, 0, BOUND_UPPER, 0, 0, 0, 0));
      op_queue.push_back(request_op(REQ_PROBE, 64'h400, '0, 0, BOUND_UPPER, 0, 0, 0, 0));
      op_queue.push_back(request_op(REQ_PROBE, '0, '0, 0, BOUND_UPPER, 0, 0, 0, 0));

      // random phases, each under its own mate threshold, extremes included
      phase_limits = '{0, 32767, 150, 0, 9900, 0, 32000, 1, 0, 32766};
      phase_limits[3] = $urandom_range(0, 32767);
      phase_limits[5] = $urandom_range(0, 32767);
      phase_limits[8] = $urandom_range(0, 32767);
      for (int p = 0; p < PHASES; p++) begin
         thr          = phase_limits[p];
         op           = request_op(REQ_UNUSED, '0, '0, 0, BOUND_UPPER, 0, 0, 0, 0);
         op.kind      = OP_SET_THRESHOLD;
         op.threshold = thr[THR_W-1:0];
         op_queue.push_back(op);
         stored_keys.delete();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) begin
               // hold the sender until the table has answered everything
               op.kind = OP_WAIT_IDLE;
               op_queue.push_back(op);
            end
            op_queue.push_back(random_op(thr, p % 4 == 3));
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (op_queue.size() != 0 || start || csr_valid || items_taken != results_seen)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_lookups.size() != 0) begin
         $error("%0d expected results never arrived", expected_lookups.size());
         error_count++;
      end
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

>>> sim.f
rtl/tt_pkg.sv
rtl/tt_mod.sv
rtl/tt_dpath.sv
rtl/tt_ctrl.sv
rtl/transposition_table.sv
tb/transposition_table_test.sv
